[rtl/core/ttwm_pkg.sv]
package ttwm_pkg;

    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam int WIDE_N = 116;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ESC   = 2'd1,
        PH_PARAM = 2'd2,
        PH_MB    = 2'd3
    } phase_t;

    localparam logic [7:0] BYTE_ESC  = 8'h1B;
    localparam logic [7:0] BYTE_LBR  = 8'h5B;

    typedef logic [20:0] cp_t;

    localparam logic [20:0] WIDE_LO [WIDE_N] = '{
        21'h01100, 21'h0231a, 21'h02329, 21'h023e9, 21'h023f0, 21'h023f3,
        21'h025fd, 21'h02614, 21'h02648, 21'h0267f, 21'h02693, 21'h026a1,
        21'h026aa, 21'h026bd, 21'h026c4, 21'h026ce, 21'h026d4, 21'h026ea,
        21'h026f2, 21'h026f5, 21'h026fa, 21'h026fd, 21'h02705, 21'h0270a,
        21'h02728, 21'h0274c, 21'h0274e, 21'h02753, 21'h02757, 21'h02795,
        21'h027b0, 21'h027bf, 21'h02b1b, 21'h02b50, 21'h02b55, 21'h02e80,
        21'h02e9b, 21'h02f00, 21'h02ff0, 21'h03000, 21'h03041, 21'h03099,
        21'h03105, 21'h03131, 21'h03190, 21'h031f0, 21'h03220, 21'h03250,
        21'h04e00, 21'h0a490, 21'h0a960, 21'h0ac00, 21'h0f900, 21'h0fe10,
        21'h0fe30, 21'h0fe54, 21'h0fe68, 21'h0ff01, 21'h0ffe0, 21'h16fe0,
        21'h16ff0, 21'h17000, 21'h18800, 21'h18d00, 21'h1b000, 21'h1b150,
        21'h1b164, 21'h1b170, 21'h1f004, 21'h1f0cf, 21'h1f18e, 21'h1f191,
        21'h1f200, 21'h1f210, 21'h1f240, 21'h1f250, 21'h1f260, 21'h1f300,
        21'h1f32d, 21'h1f337, 21'h1f37e, 21'h1f3a0, 21'h1f3cf, 21'h1f3e0,
        21'h1f3f4, 21'h1f3f8, 21'h1f440, 21'h1f442, 21'h1f4ff, 21'h1f54b,
        21'h1f550, 21'h1f57a, 21'h1f595, 21'h1f5a4, 21'h1f5fb, 21'h1f680,
        21'h1f6cc, 21'h1f6d0, 21'h1f6d5, 21'h1f6eb, 21'h1f6f4, 21'h1f7e0,
        21'h1f90c, 21'h1f93c, 21'h1f947, 21'h1f97a, 21'h1f9cd, 21'h1fa70,
        21'h1fa78, 21'h1fa80, 21'h1fa90, 21'h1fab0, 21'h1fac0, 21'h1fad0,
        21'h20000, 21'h30000
    };

    localparam logic [20:0] WIDE_HI [WIDE_N] = '{
        21'h0115f, 21'h0231b, 21'h0232a, 21'h023ec, 21'h023f0, 21'h023f3,
        21'h025fe, 21'h02615, 21'h02653, 21'h0267f, 21'h02693, 21'h026a1,
        21'h026ab, 21'h026be, 21'h026c5, 21'h026ce, 21'h026d4, 21'h026ea,
        21'h026f3, 21'h026f5, 21'h026fa, 21'h026fd, 21'h02705, 21'h0270b,
        21'h02728, 21'h0274c, 21'h0274e, 21'h02755, 21'h02757, 21'h02797,
        21'h027b0, 21'h027bf, 21'h02b1c, 21'h02b50, 21'h02b55, 21'h02e99,
        21'h02ef3, 21'h02fd5, 21'h02ffb, 21'h0303e, 21'h03096, 21'h030ff,
        21'h0312f, 21'h0318e, 21'h031e3, 21'h0321e, 21'h03247, 21'h04dbf,
        21'h0a48c, 21'h0a4c6, 21'h0a97c, 21'h0d7a3, 21'h0faff, 21'h0fe19,
        21'h0fe52, 21'h0fe66, 21'h0fe6b, 21'h0ff60, 21'h0ffe6, 21'h16fe4,
        21'h16ff1, 21'h187f7, 21'h18cd5, 21'h18d08, 21'h1b11e, 21'h1b152,
        21'h1b167, 21'h1b2fb, 21'h1f004, 21'h1f0cf, 21'h1f18e, 21'h1f19a,
        21'h1f202, 21'h1f23b, 21'h1f248, 21'h1f251, 21'h1f265, 21'h1f320,
        21'h1f335, 21'h1f37c, 21'h1f393, 21'h1f3ca, 21'h1f3d3, 21'h1f3f0,
        21'h1f3f4, 21'h1f43e, 21'h1f440, 21'h1f4fc, 21'h1f53d, 21'h1f54e,
        21'h1f567, 21'h1f57a, 21'h1f596, 21'h1f5a4, 21'h1f64f, 21'h1f6c5,
        21'h1f6cc, 21'h1f6d2, 21'h1f6d7, 21'h1f6ec, 21'h1f6fc, 21'h1f7eb,
        21'h1f93a, 21'h1f945, 21'h1f978, 21'h1f9cb, 21'h1f9ff, 21'h1fa74,
        21'h1fa7a, 21'h1fa86, 21'h1faa8, 21'h1fab6, 21'h1fac2, 21'h1fad6,
        21'h2fffd, 21'h3fffd
    };

    // range compares are independent, OR-reduced
    function automatic logic is_wide(input cp_t cp);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < WIDE_N; k++)
        begin
            if (cp >= WIDE_LO[k] && cp <= WIDE_HI[k])
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    localparam int REG_MAX_WIDTH  = 0;
    localparam int REG_WIDTH_RULE = 1;

endpackage

[rtl/core/terminal_text_width_meter_top.sv]
// Terminal text width meter. Feed a string one byte per item on s_axis
// (tdata = data_byte, tuser = has_byte, tlast ends the string); at the item
// with tlast one result comes out on m_axis: total display width, byte length
// of the longest prefix that fits max_width, and a cut flag. Complete CSI
// escapes take no width; under width_rule 0 UTF-8 is decoded and checked
// against a wide-character range table, under rule 1 bytes are classed.
// One item is taken every cycle: the byte is decoded, compared against the
// table and the counters updated as it is taken, and the result sits in an
// output register that frees as soon as it is taken, so s_axis_tready only
// drops while a result is held and not taken. Counters saturate at 65535.
// Configuration writes must happen only while no string is in progress.
module terminal_text_width_meter_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [15:0] total_width, [31:16] cut_length,
                                        // [32] was_cut, [39:33] zero
);

    localparam int W = ttwm_pkg::CNT_W;

    logic [15:0]   max_width_reg;
    logic          width_rule_reg;

    ttwm_pkg::phase_t phase_reg, phase_next;
    logic [1:0]    left_reg, left_next;
    ttwm_pkg::cp_t cp_reg, cp_next;
    logic          ok_reg, ok_next;
    logic [15:0]   esc_reg, esc_next;
    logic [W-1:0]  tot_reg, tot_next;
    logic [W-1:0]  idx_reg, idx_next;
    logic [W-1:0]  cstart_reg, cstart_next;
    logic [W-1:0]  cut_reg, cut_next;
    logic          found_reg, found_next;

    logic          ovalid_reg;
    logic [39:0]   odata_reg, odata_next;

    logic          accept;

    assign s_axis_tready = !ovalid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_width_reg  <= 16'hFFFF;
            width_rule_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == 1'(ttwm_pkg::REG_MAX_WIDTH))
            begin
                max_width_reg <= cfg_wdata;
            end
            else
            begin
                width_rule_reg <= cfg_wdata[0];
            end
        end
    end

    // saturating add of a count to the running width
    function automatic logic [W:0] sat_add(input logic [W-1:0] a, input logic [16:0] b);
        logic [W+1:0] s;
        s = {2'b0, a} + (W+2)'(b);
        return (s > (W+2)'(ttwm_pkg::CNT_MAX)) ? {1'b0, ttwm_pkg::CNT_MAX} : s[W:0];
    endfunction

    always_comb
    begin
        logic [7:0]   b;
        logic         restart;
        logic         ch_en;
        logic [1:0]   ch_w;
        logic [W-1:0] ch_pos;
        logic [W+1:0] sum;
        logic [W-1:0] pos;
        logic [W-1:0] estart;
        logic [W+1:0] room;
        logic [W+1:0] tmp;
        logic [W+1:0] ecut;
        logic         flush;
        logic [2:0]   len;

        b           = s_axis_tdata;
        pos         = idx_reg;
        phase_next  = phase_reg;
        left_next   = left_reg;
        cp_next     = cp_reg;
        ok_next     = ok_reg;
        esc_next    = esc_reg;
        tot_next    = tot_reg;
        idx_next    = idx_reg;
        cstart_next = cstart_reg;
        cut_next    = cut_reg;
        found_next  = found_reg;
        odata_next  = odata_reg;
        restart     = 1'b0;
        ch_en       = 1'b0;
        ch_w        = 2'd0;
        ch_pos      = pos;
        flush       = 1'b0;
        estart      = '0;
        room        = '0;
        tmp         = '0;
        ecut        = '0;
        sum         = '0;
        len         = '0;

        if (accept && s_axis_tuser)
        begin
            if (idx_reg != ttwm_pkg::CNT_MAX)
            begin
                idx_next = idx_reg + 1'b1;
            end
            unique case (phase_reg)
                ttwm_pkg::PH_MB:
                begin
                    if (b[7:6] != 2'b10)
                    begin
                        ok_next = 1'b0;
                    end
                    else
                    begin
                        cp_next = {cp_reg[14:0], b[5:0]};
                    end
                    if (left_reg <= 2'd1)
                    begin
                        ch_en       = 1'b1;
                        ch_pos      = cstart_reg;
                        ch_w        = (ok_next && ttwm_pkg::is_wide(cp_next)) ? 2'd2 : 2'd1;
                        phase_next  = ttwm_pkg::PH_IDLE;
                        cp_next     = '0;
                        ok_next     = 1'b1;
                        left_next   = 2'd0;
                    end
                    else
                    begin
                        left_next = left_reg - 2'd1;
                    end
                end
                ttwm_pkg::PH_ESC:
                begin
                    if (b == ttwm_pkg::BYTE_LBR)
                    begin
                        phase_next = ttwm_pkg::PH_PARAM;
                        esc_next   = esc_reg + 16'd1;
                    end
                    else
                    begin
                        flush   = 1'b1;
                        restart = 1'b1;
                    end
                end
                ttwm_pkg::PH_PARAM:
                begin
                    if (b >= 8'h20 && b <= 8'h3F)
                    begin
                        if (esc_reg != 16'hFFFF)
                        begin
                            esc_next = esc_reg + 16'd1;
                        end
                    end
                    else if (b >= 8'h40 && b <= 8'h7E)
                    begin
                        esc_next   = '0;
                        phase_next = ttwm_pkg::PH_IDLE;
                    end
                    else
                    begin
                        flush   = 1'b1;
                        restart = 1'b1;
                    end
                end
                default:
                begin
                    restart = 1'b1;
                end
            endcase
        end

        // escape flush (esc pending bytes counted at width 1 each)
        if (flush)
        begin
            estart = (idx_reg >= W'(esc_reg)) ? idx_reg - W'(esc_reg) : '0;
            tmp    = {2'b0, tot_reg} + (W+2)'(esc_reg);
            if (!found_reg && tmp > (W+2)'(max_width_reg))
            begin
                room       = ((W+2)'(max_width_reg) > {2'b0, tot_reg}) ?
                             (W+2)'(max_width_reg) - {2'b0, tot_reg} : '0;
                ecut       = {2'b0, estart} + room;
                found_next = 1'b1;
                cut_next   = (ecut > (W+2)'(ttwm_pkg::CNT_MAX)) ? ttwm_pkg::CNT_MAX : ecut[W-1:0];
            end
            tot_next   = W'(sat_add(tot_reg, {1'b0, esc_reg}));
            esc_next   = '0;
            phase_next = ttwm_pkg::PH_IDLE;
        end

        // start of a character
        if (restart)
        begin
            if (b == ttwm_pkg::BYTE_ESC)
            begin
                phase_next = ttwm_pkg::PH_ESC;
                esc_next   = 16'd1;
            end
            else if (width_rule_reg)
            begin
                if (b[7] == 1'b0)
                begin
                    ch_en = 1'b1;
                    ch_w  = 2'd1;
                end
                else if (b[6])
                begin
                    ch_en = 1'b1;
                    ch_w  = 2'd2;
                end
            end
            else if (b[7] == 1'b0)
            begin
                ch_en = 1'b1;
                ch_w  = 2'd1;
            end
            else
            begin
                priority if ((b & 8'hE0) == 8'hC0) len = 3'd2;
                else if ((b & 8'hF0) == 8'hE0) len = 3'd3;
                else if ((b & 8'hF8) == 8'hF0) len = 3'd4;
                else len = 3'd0;
                if (len == 3'd0)
                begin
                    ch_en = 1'b1;
                    ch_w  = 2'd1;
                end
                else
                begin
                    cstart_next = pos;
                    cp_next     = 21'(b & (8'hFF >> (len + 3'd1)));
                    left_next   = 2'(len - 3'd1);
                    ok_next     = 1'b1;
                    phase_next  = ttwm_pkg::PH_MB;
                end
            end
        end

        // charge (uses flushed total when both happen)
        if (ch_en)
        begin
            sum = {2'b0, tot_next} + (W+2)'(ch_w);
            if (!found_next && sum > (W+2)'(max_width_reg))
            begin
                found_next = 1'b1;
                cut_next   = ch_pos;
            end
            tot_next = (sum > (W+2)'(ttwm_pkg::CNT_MAX)) ? ttwm_pkg::CNT_MAX : sum[W-1:0];
        end

        // end of string: a pending escape is flushed, an unfinished character
        // counts as width 1 at its first byte
        if (accept && s_axis_tlast)
        begin
            if (phase_next == ttwm_pkg::PH_ESC || phase_next == ttwm_pkg::PH_PARAM)
            begin
                estart = (idx_next >= W'(esc_next)) ? idx_next - W'(esc_next) : '0;
                tmp    = {2'b0, tot_next} + (W+2)'(esc_next);
                if (!found_next && tmp > (W+2)'(max_width_reg))
                begin
                    room       = ((W+2)'(max_width_reg) > {2'b0, tot_next}) ?
                                 (W+2)'(max_width_reg) - {2'b0, tot_next} : '0;
                    ecut       = {2'b0, estart} + room;
                    found_next = 1'b1;
                    cut_next   = (ecut > (W+2)'(ttwm_pkg::CNT_MAX)) ?
                                 ttwm_pkg::CNT_MAX : ecut[W-1:0];
                end
                tot_next = W'(sat_add(tot_next, {1'b0, esc_next}));
            end
            else if (phase_next == ttwm_pkg::PH_MB)
            begin
                sum = {2'b0, tot_next} + (W+2)'(2'd1);
                if (!found_next && sum > (W+2)'(max_width_reg))
                begin
                    found_next = 1'b1;
                    cut_next   = cstart_next;
                end
                tot_next = (sum > (W+2)'(ttwm_pkg::CNT_MAX)) ? ttwm_pkg::CNT_MAX : sum[W-1:0];
            end

            odata_next  = {7'd0, found_next,
                           16'(found_next ? cut_next : idx_next), 16'(tot_next)};
            phase_next  = ttwm_pkg::PH_IDLE;
            left_next   = '0;
            cp_next     = '0;
            ok_next     = 1'b1;
            esc_next    = '0;
            tot_next    = '0;
            idx_next    = '0;
            cstart_next = '0;
            cut_next    = '0;
            found_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= ttwm_pkg::PH_IDLE;
            left_reg   <= '0;
            cp_reg     <= '0;
            ok_reg     <= 1'b1;
            esc_reg    <= '0;
            tot_reg    <= '0;
            idx_reg    <= '0;
            cstart_reg <= '0;
            cut_reg    <= '0;
            found_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            left_reg   <= left_next;
            cp_reg     <= cp_next;
            ok_reg     <= ok_next;
            esc_reg    <= esc_next;
            tot_reg    <= tot_next;
            idx_reg    <= idx_next;
            cstart_reg <= cstart_next;
            cut_reg    <= cut_next;
            found_reg  <= found_next;
            if (accept && s_axis_tlast)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        odata_reg <= odata_next;
    end

endmodule
